// ----- rtl/core/smu_pkg.sv -----
// Package with the widths, payload types and helpers of the segment midpoint and axis block.
`timescale 1ns / 1ps
package smu_pkg;

  // Field widths.
  localparam int COORD_BITS     = 24;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int DIR_BITS       = AXIS_FRAC_BITS + 2;

  // Internal widths: magnitude of a difference, sum of squares, root and quotient.
  localparam int MAG_W = COORD_BITS;
  localparam int SQ_W  = 2 * MAG_W + 2;
  localparam int ROOT_W = MAG_W + 1;
  localparam int QUO_W = AXIS_FRAC_BITS + 1;
  localparam int NUM_W = MAG_W + AXIS_FRAC_BITS;

  // Pipeline depth: front end, one stage per root bit, one per quotient bit, output register.
  localparam int FRONT_STAGES = 3;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W + QUO_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
  } smu_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] mid_x;
    logic signed [COORD_BITS-1:0] mid_y;
    logic signed [COORD_BITS-1:0] mid_z;
    logic signed [DIR_BITS-1:0]   dir_x;
    logic signed [DIR_BITS-1:0]   dir_y;
    logic signed [DIR_BITS-1:0]   dir_z;
    logic                         zero_length;
  } smu_out_t;

  // Applies the sign of the difference to a quotient magnitude.
  function automatic logic [DIR_BITS-1:0] smu_signed_dir(input logic [QUO_W-1:0] mag,
                                                         input logic neg);
    logic [DIR_BITS-1:0] ext;
    ext = DIR_BITS'(mag);
    return neg ? (~ext + DIR_BITS'(1)) : ext;
  endfunction

endpackage

// ----- rtl/core/smu_delay.sv -----
// Enabled shift register that keeps side data aligned with the pipeline.
`timescale 1ns / 1ps
module smu_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  // Each tap moves one step when the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ----- rtl/core/smu_front.sv -----
// Front end: differences, midpoints, magnitudes and the sum of squares over three stages.
`timescale 1ns / 1ps
module smu_front import smu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  smu_in_t               req_i,
  output logic [3*COORD_BITS-1:0] mid_o,
  output logic [3*MAG_W-1:0]    mag_o,
  output logic [2:0]            neg_o,
  output logic [SQ_W-1:0]       sq_o
);

  localparam int DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] a [3];
  logic signed [COORD_BITS-1:0] b [3];
  logic signed [DW-1:0] diff_d [3];
  logic signed [DW-1:0] diff_q [3];
  logic [3*COORD_BITS-1:0] mid_d, mid1_q, mid2_q, mid3_q;
  logic [MAG_W-1:0] mag_d [3];
  logic [MAG_W-1:0] mag2_q [3];
  logic [MAG_W-1:0] mag3_q [3];
  logic [2:0] neg2_q, neg3_q;
  logic [2*MAG_W-1:0] sqr_d [3];
  logic [2*MAG_W-1:0] sqr_q [3];
  logic [SQ_W-1:0] sum_q;

  assign a[0] = req_i.first_x;
  assign a[1] = req_i.first_y;
  assign a[2] = req_i.first_z;
  assign b[0] = req_i.second_x;
  assign b[1] = req_i.second_y;
  assign b[2] = req_i.second_z;

  // Stage one logic: difference and floor half of the sum.
  always_comb begin
    logic signed [DW-1:0] s;
    for (int k = 0; k < 3; k++) begin
      diff_d[k] = DW'(b[k]) - DW'(a[k]);
      s = DW'(b[k]) + DW'(a[k]);
      mid_d[(2-k)*COORD_BITS +: COORD_BITS] = s[DW-1:1];
    end
  end

  // Stage two logic: magnitude and its square.
  always_comb begin
    logic [DW-1:0] m;
    for (int k = 0; k < 3; k++) begin
      m = diff_q[k][DW-1] ? (~diff_q[k] + DW'(1)) : diff_q[k];
      mag_d[k] = m[MAG_W-1:0];
      sqr_d[k] = (2*MAG_W)'(mag_d[k]) * (2*MAG_W)'(mag_d[k]);
    end
  end

  // Three register stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= diff_d[k];
        mag2_q[k] <= mag_d[k];
        sqr_q[k]  <= sqr_d[k];
        neg2_q[k] <= diff_q[k][DW-1];
        mag3_q[k] <= mag2_q[k];
      end
      mid1_q <= mid_d;
      mid2_q <= mid1_q;
      mid3_q <= mid2_q;
      neg3_q <= neg2_q;
      sum_q  <= SQ_W'(sqr_q[0]) + SQ_W'(sqr_q[1]) + SQ_W'(sqr_q[2]);
    end
  end

  assign mid_o = mid3_q;
  assign mag_o = {mag3_q[0], mag3_q[1], mag3_q[2]};
  assign neg_o = neg3_q;
  assign sq_o  = sum_q;

endmodule

// ----- rtl/core/smu_isqrt.sv -----
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps
module smu_isqrt import smu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   n_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int CW = 2 * ROOT_W + 1;

  logic [SQ_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int BIT = ROOT_W - 1 - k;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [CW-1:0]     cand;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = n_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Try setting this bit: (r + 2^i)^2 - r^2 = 2*r*2^i + 4^i.
    assign cand = (CW'(root_in) << (BIT + 1)) | (CW'(1) << (2 * BIT));
    assign take = CW'(rem_in) >= cand;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_in - cand[SQ_W-1:0]) : rem_in;
        root_q[k] <= take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ----- rtl/core/smu_div.sv -----
// Pipelined restoring divider of a scaled magnitude by the length, one quotient bit per stage.
`timescale 1ns / 1ps
module smu_div import smu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MAG_W-1:0]  mag_i,
  input  logic [ROOT_W-1:0] len_i,
  output logic [QUO_W-1:0]  quo_o
);

  localparam int CW = NUM_W + ROOT_W;

  logic [NUM_W-1:0]  rem_q [QUO_W];
  logic [ROOT_W-1:0] len_q [QUO_W];
  logic [QUO_W-1:0]  quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int BIT = QUO_W - 1 - k;
    logic [NUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] len_in;
    logic [QUO_W-1:0]  quo_in;
    logic [CW-1:0]     dsh;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = NUM_W'(mag_i) << AXIS_FRAC_BITS;
      assign len_in = len_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign len_in = len_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // The quotient is at most 2^frac, so the top bit needs no earlier step.
    assign dsh  = CW'(len_in) << BIT;
    assign take = CW'(rem_in) >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? (rem_in - dsh[NUM_W-1:0]) : rem_in;
        len_q[k] <= len_in;
        quo_q[k] <= take ? (quo_in | (QUO_W'(1) << BIT)) : quo_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// ----- rtl/core/segment_midpoint_and_unit_axis_top.sv -----
// Top level of the segment midpoint and unit axis pipeline.
//
// Takes one request per cycle while in_ready_o is high and returns the midpoint and the
// Q2.14 unit direction from the first point to the second. The pipeline is three front-end
// stages (difference, square, sum), one stage per bit of the 25-bit square root, one stage per
// bit of the 15-bit quotient, and one output register. When the result is not taken, the
// whole pipeline holds and in_ready_o drops in the same cycle. Coincident points give
// zero_length set and a zero direction; the midpoint is still produced.
`timescale 1ns / 1ps
module segment_midpoint_and_unit_axis_top import smu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  smu_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output smu_out_t out_req_o
);

  logic                    en;
  logic [LATENCY-1:0]      vld_q;
  logic [3*COORD_BITS-1:0] mid_f;
  logic [3*MAG_W-1:0]      mag_f, mag_a;
  logic [2:0]              neg_f;
  logic [SQ_W-1:0]         sq_f;
  logic [ROOT_W-1:0]       len;
  logic [QUO_W-1:0]        quo [3];
  logic [3*COORD_BITS+3:0] side_d, side_a;
  smu_out_t                out_d, out_q;

  // The pipeline advances unless a finished result is held at the output.
  assign en         = ~vld_q[LATENCY-1] | out_ready_i;
  assign in_ready_o = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
    end
  end

  smu_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (in_req_i),
    .mid_o (mid_f),
    .mag_o (mag_f),
    .neg_o (neg_f),
    .sq_o  (sq_f)
  );

  smu_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (sq_f),
    .root_o (len)
  );

  // Magnitudes wait for the root.
  smu_delay #(.W(3 * MAG_W), .DEPTH(ROOT_W)) u_mag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (mag_f),
    .q_o   (mag_a)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    smu_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (mag_a[(2-k)*MAG_W +: MAG_W]),
      .len_i (len),
      .quo_o (quo[k])
    );
  end

  // Midpoint, signs and the zero flag wait for the quotients.
  assign side_d = {mid_f, neg_f, (sq_f == '0)};

  smu_delay #(.W(3 * COORD_BITS + 4), .DEPTH(ROOT_W + QUO_W)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side_d),
    .q_o   (side_a)
  );

  // Result assembly; the sign of x sits in the lowest sign bit.
  always_comb begin
    logic zl;
    zl = side_a[0];
    out_d.mid_x       = side_a[4+2*COORD_BITS +: COORD_BITS];
    out_d.mid_y       = side_a[4+COORD_BITS +: COORD_BITS];
    out_d.mid_z       = side_a[4 +: COORD_BITS];
    out_d.dir_x       = zl ? '0 : smu_signed_dir(quo[0], side_a[1]);
    out_d.dir_y       = zl ? '0 : smu_signed_dir(quo[1], side_a[2]);
    out_d.dir_z       = zl ? '0 : smu_signed_dir(quo[2], side_a[3]);
    out_d.zero_length = zl;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[LATENCY-1];
  assign out_req_o   = out_q;

  // A held result stalls the input side in the same cycle.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the output is stalled");

  // Coincident points give a zero direction.
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.zero_length |->
      out_req_o.dir_x == '0 && out_req_o.dir_y == '0 && out_req_o.dir_z == '0)
    else $error("nonzero direction with zero length");

  // The x direction component stays within one unit.
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_req_o.dir_x <= DIR_BITS'(1 << AXIS_FRAC_BITS) &&
      out_req_o.dir_x >= -DIR_BITS'(1 << AXIS_FRAC_BITS))
    else $error("direction component out of range");

endmodule
